>>> sv/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, constants and helpers of the text charset detector.
// ----------------------------------------------------------------------------
package tcd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned SetBytes    = 6;
  localparam int unsigned SetW        = ByteW * SetBytes;
  localparam int unsigned HitW        = 24;
  localparam int unsigned CountWidthD = 24;
  localparam int unsigned PendW       = 3;
  localparam int unsigned CsW         = 2;

  // master tdata: charset, iso_hits, cp_hits, zero padded to whole bytes
  localparam int unsigned OutFieldW = CsW + 2 * HitW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // configuration port
  localparam int unsigned ApbDataW = 64;
  localparam int unsigned ApbAddrW = 4;

  typedef enum logic {
    REG_ISO_LETTERS = 1'b0,
    REG_CP_LETTERS  = 1'b1
  } reg_idx_e;

  typedef enum logic [CsW-1:0] {
    CS_UTF8    = 2'd0,
    CS_CP1250  = 2'd1,
    CS_ISO8859 = 2'd2
  } charset_e;

  localparam logic [SetW-1:0] IsoLettersRst = 48'hB1B6_BCA1_A6AC;
  localparam logic [SetW-1:0] CpLettersRst  = 48'hB99C_9FA5_8C8F;

  localparam logic [PendW-1:0] PendMax = 3'd5;

  // byte found in any of the six packed slots
  function automatic logic in_set(input logic [SetW-1:0] set_bytes,
                                  input logic [ByteW-1:0] b);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < SetBytes; k++) begin
      if (set_bytes[k*ByteW +: ByteW] == b) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> sv/text_charset_detector_top.sv
// ----------------------------------------------------------------------------
// text_charset_detector_top
// Old-form UTF-8 sequence check plus ISO-8859-2 / CP1250 letter counting,
// one text byte per cycle while no final byte waits on a held result; verdict on the final byte.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  s_axis   | in  | tvalid / tready   | tdata[7:0] text_byte, tlast is_final
//  m_axis   | out | tvalid / tready   | tdata charset, iso_hits, cp_hits
//  apb      | in  | psel/penable/pready | 64-bit regs at 0x0 (iso), 0x8 (cp)
//
//  One byte per cycle sustained while no final byte waits; each byte passes
//  the input register and is then processed into the result register. The
//  scan state is updated as the byte leaves the input register.
//  Non-final bytes never wait on the output side; a final byte waits only
//  while an earlier result is still held in the result register.
//  Reset restores the letter sets and clears the scan state; no clear pass.
// ----------------------------------------------------------------------------
module text_charset_detector_top #(
  parameter int unsigned COUNT_WIDTH = tcd_pkg::CountWidthD
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tcd_pkg::ByteW-1:0]     s_axis_tdata_i,  // [7:0] text_byte
  input  logic                          s_axis_tlast_i,  // is_final

  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [1:0] charset, [25:2] iso_hits, [49:26] cp_hits, [55:50] zero
  output logic [tcd_pkg::OutDataW-1:0]  m_axis_tdata_o,

  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [tcd_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [tcd_pkg::ApbDataW-1:0]  pwdata_i,
  output logic [tcd_pkg::ApbDataW-1:0]  prdata_o,
  output logic                          pready_o
);
  import tcd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  // configuration
  logic [SetW-1:0] iso_set_q, cp_set_q;
  logic            reg_sel;
  logic            cfg_we;

  assign pready_o = 1'b1;
  assign reg_sel  = paddr_i[ApbAddrW-1];
  assign cfg_we   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_set_q <= IsoLettersRst;
      cp_set_q  <= CpLettersRst;
    end else if (cfg_we) begin
      if (reg_sel == REG_ISO_LETTERS) begin
        iso_set_q <= pwdata_i[SetW-1:0];
      end else begin
        cp_set_q <= pwdata_i[SetW-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_ISO_LETTERS) begin
      prdata_o = ApbDataW'(iso_set_q);
    end else begin
      prdata_o = ApbDataW'(cp_set_q);
    end
  end

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             adv;
  logic             out_vld_q;

  assign adv             = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // scan state
  logic [PendW-1:0]       pend_q, pend_d;
  logic                   utf_ok_q, utf_ok_d;
  logic                   ended_q, ended_d;
  logic [COUNT_WIDTH-1:0] iso_cnt_q, iso_cnt_d;
  logic [COUNT_WIDTH-1:0] cp_cnt_q, cp_cnt_d;
  logic                   iso_hit, cp_hit;

  assign iso_hit = in_set(iso_set_q, in_byte_q);
  assign cp_hit  = in_set(cp_set_q, in_byte_q);

  always_comb begin
    pend_d    = pend_q;
    utf_ok_d  = utf_ok_q;
    ended_d   = ended_q;
    iso_cnt_d = iso_cnt_q;
    cp_cnt_d  = cp_cnt_q;
    if (!ended_q) begin
      if (in_byte_q == '0) begin
        ended_d = 1'b1;
      end else begin
        if (iso_hit) begin
          if (iso_cnt_q != CountMax) iso_cnt_d = iso_cnt_q + COUNT_WIDTH'(1);
        end else if (cp_hit) begin
          if (cp_cnt_q != CountMax) cp_cnt_d = cp_cnt_q + COUNT_WIDTH'(1);
        end
        if (utf_ok_q) begin
          if (pend_q != '0) begin
            if (in_byte_q[7:6] != 2'b10) utf_ok_d = 1'b0;
            else                         pend_d   = pend_q - 3'd1;
          end else if (in_byte_q[7]) begin
            if      (in_byte_q[7:5] == 3'b110)    pend_d   = 3'd1;
            else if (in_byte_q[7:4] == 4'b1110)   pend_d   = 3'd2;
            else if (in_byte_q[7:3] == 5'b11110)  pend_d   = 3'd3;
            else if (in_byte_q[7:2] == 6'b111110) pend_d   = 3'd4;
            else if (in_byte_q[7:1] == 7'b1111110) pend_d  = PendMax;
            else                                  utf_ok_d = 1'b0;
          end
        end
      end
    end
  end

  // result from the updated state
  charset_e cs_d;
  always_comb begin
    if (utf_ok_d)                  cs_d = CS_UTF8;
    else if (iso_cnt_d < cp_cnt_d) cs_d = CS_CP1250;
    else                           cs_d = CS_ISO8859;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      utf_ok_q  <= 1'b1;
      ended_q   <= 1'b0;
      iso_cnt_q <= '0;
      cp_cnt_q  <= '0;
    end else if (adv) begin
      if (in_last_q) begin
        pend_q    <= '0;
        utf_ok_q  <= 1'b1;
        ended_q   <= 1'b0;
        iso_cnt_q <= '0;
        cp_cnt_q  <= '0;
      end else begin
        pend_q    <= pend_d;
        utf_ok_q  <= utf_ok_d;
        ended_q   <= ended_d;
        iso_cnt_q <= iso_cnt_d;
        cp_cnt_q  <= cp_cnt_d;
      end
    end
  end

  // result register
  logic [OutDataW-1:0] out_data_q;
  logic                res_load;

  assign res_load = adv && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= OutDataW'({HitW'(cp_cnt_d), HitW'(iso_cnt_d), cs_d});
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // checks
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendMax)
    else $error("pending continuation count out of range");

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (pend_q == '0 && utf_ok_q && !ended_q &&
                  iso_cnt_q == '0 && cp_cnt_q == '0))
    else $error("scan state not cleared after final byte");

  a_ended_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q && adv && !in_last_q |=>
      ($stable(iso_cnt_q) && $stable(cp_cnt_q) && $stable(pend_q) && $stable(utf_ok_q)))
    else $error("state changed after end of scan");

  a_charset_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_data_q[CsW-1:0] != 2'd3)
    else $error("invalid charset code in result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_vld_q || m_axis_tready_i))
    else $error("result register overwritten before delivery");

endmodule

>>> tb/sv/text_charset_detector_top_tb.sv
// ----------------------------------------------------------------------------
// text_charset_detector_top_tb
// Streams text buffers into the detector and scores every verdict word
// against an in-bench model of the UTF-8 sequence check and letter counters.
// The letter sets are rewritten between phases over APB and read back.
// ----------------------------------------------------------------------------
module text_charset_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcd_pkg::*;

  localparam int CntW        = CountWidthD;
  localparam int PhaseItems  = 188;
  localparam int NumPhases   = 6;
  localparam int LongHold    = 200;

  // {is_final, text_byte}
  localparam logic [8:0] DirectedText [22] = '{
    9'h0C5, 9'h082, 9'h141,
    9'h0FC, 9'h080, 9'h080, 9'h080, 9'h080, 9'h1BF,
    9'h0E0, 9'h180,
    9'h0B1, 9'h09C, 9'h0B9, 9'h18C,
    9'h0FE, 9'h000, 9'h1A1,
    9'h100,
    9'h0C3, 9'h041, 9'h1FF
  };

  typedef struct {
    charset_e         cs;
    logic [HitW-1:0]  iso;
    logic [HitW-1:0]  cp;
  } verdict_t;

  class charset_verdict_board;
    logic [SetW-1:0]  iso_set;
    logic [SetW-1:0]  cp_set;
    logic [PendW-1:0] cont_left;
    bit               utf_ok;
    bit               stopped;
    logic [CntW-1:0]  iso_cnt;
    logic [CntW-1:0]  cp_cnt;
    verdict_t         pending_verdicts[$];
    int               errors;
    int               bytes_seen;
    int               verdicts_seen;
    int               cs_count[3];

    function new();
      iso_set = IsoLettersRst;
      cp_set  = CpLettersRst;
      errors = 0;
      bytes_seen = 0;
      verdicts_seen = 0;
      cs_count = '{0, 0, 0};
      clear_scan();
    endfunction

    function void clear_scan();
      cont_left = '0;
      utf_ok    = 1'b1;
      stopped   = 1'b0;
      iso_cnt   = '0;
      cp_cnt    = '0;
    endfunction

    function bit holds(logic [SetW-1:0] set_bytes, logic [7:0] b);
      logic [SetW-1:0] s;
      bit found;
      s = set_bytes;
      found = 1'b0;
      repeat (SetBytes) begin
        if (s[7:0] == b) found = 1'b1;
        s = s >> 8;
      end
      return found;
    endfunction

    function void take_byte(logic [7:0] b, bit last);
      verdict_t v;
      bytes_seen++;
      if (!stopped) begin
        if (b == 8'h00) begin
          stopped = 1'b1;
        end else begin
          if (holds(iso_set, b)) begin
            if (iso_cnt != '1) iso_cnt++;
          end else if (holds(cp_set, b)) begin
            if (cp_cnt != '1) cp_cnt++;
          end
          if (utf_ok) begin
            if (cont_left != 0) begin
              if (b[7:6] != 2'b10) utf_ok = 1'b0;
              else cont_left--;
            end else if (b[7]) begin
              casez (b)
                8'b110?_????: cont_left = 3'd1;
                8'b1110_????: cont_left = 3'd2;
                8'b1111_0???: cont_left = 3'd3;
                8'b1111_10??: cont_left = 3'd4;
                8'b1111_110?: cont_left = 3'd5;
                default:      utf_ok = 1'b0;
              endcase
            end
          end
        end
      end
      if (last) begin
        if (utf_ok) v.cs = CS_UTF8;
        else if (iso_cnt < cp_cnt) v.cs = CS_CP1250;
        else v.cs = CS_ISO8859;
        v.iso = HitW'(iso_cnt);
        v.cp  = HitW'(cp_cnt);
        pending_verdicts.push_back(v);
        clear_scan();
      end
    endfunction

    function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_verdict(logic [OutDataW-1:0] d);
      verdict_t v;
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("verdict word 0x%0h with none outstanding", d);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      cs_count[v.cs]++;
      field_check("charset", 64'(v.cs), 64'(d[CsW-1:0]));
      field_check("iso_hits", 64'(v.iso), 64'(d[CsW +: HitW]));
      field_check("cp_hits", 64'(v.cp), 64'(d[CsW+HitW +: HitW]));
      field_check("pad", 64'd0, 64'(d[OutDataW-1:OutFieldW]));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_n;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [ByteW-1:0]     s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutDataW-1:0]  m_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ApbAddrW-1:0]  paddr;
  logic [ApbDataW-1:0]  pwdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  charset_verdict_board board = new();
  logic [7:0] text_q[$];
  int burst_left = 0;
  int stall_cycles = 0;
  int reg_writes = 0;

  text_charset_detector_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) board.check_verdict(m_tdata);
      if (s_tvalid && !s_tready) stall_cycles++;
    end
  end

  // receiver: changing ready patterns, one long hold-off once results flow
  initial begin
    int hold_left;
    int seg_left;
    int mode;
    int tick;
    bit held_once;
    hold_left = 0;
    seg_left = 0;
    mode = 0;
    tick = 0;
    held_once = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (!held_once && board.verdicts_seen >= 30) begin
        held_once = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (mode)
          0, 1:    m_tready <= 1'b1;
          2:       m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  task automatic offer(input logic [7:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom_range(0, 255));
        s_tlast  <= 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    board.take_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic apb_access(input reg_idx_e idx, input bit wr,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic read_check(input reg_idx_e idx);
    logic [63:0] got;
    apb_access(idx, 1'b0, 64'd0, got);
    if (idx == REG_ISO_LETTERS) board.field_check("iso_letter_bytes", 64'(board.iso_set), got);
    else board.field_check("cp_letter_bytes", 64'(board.cp_set), got);
  endtask

  task automatic set_reg(input reg_idx_e idx, input logic [63:0] val);
    logic [63:0] unused;
    apb_access(idx, 1'b1, val, unused);
    reg_writes++;
    if (idx == REG_ISO_LETTERS) board.iso_set = val[SetW-1:0];
    else board.cp_set = val[SetW-1:0];
    read_check(idx);
  endtask

  task automatic load_sets(input int phase);
    logic [63:0] iso_v;
    logic [63:0] cp_v;
    iso_v = {$urandom, $urandom};
    cp_v  = {$urandom, $urandom};
    case (phase)
      1: begin
        iso_v = 64'hFFFF_0000_0000_0000;
        cp_v  = 64'h0000_0000_0000_0000;
      end
      2: begin
        iso_v = 64'h0000_FFFF_FFFF_FFFF;
        cp_v  = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      3: cp_v = {cp_v[63:48], iso_v[47:24], cp_v[23:0]};
      5: begin
        iso_v = 64'(IsoLettersRst);
        cp_v  = 64'(CpLettersRst);
      end
      default: ;
    endcase
    set_reg(REG_ISO_LETTERS, iso_v);
    set_reg(REG_CP_LETTERS, cp_v);
  endtask

  function automatic logic [7:0] lead_byte(int conts);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (conts)
      1:       return {3'b110, r[4:0]};
      2:       return {4'b1110, r[3:0]};
      3:       return {5'b11110, r[2:0]};
      4:       return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  // mostly well-formed sequences; some letter-heavy, noisy or corrupted text
  function automatic void build_text();
    int kind;
    int nseq;
    int k;
    text_q.delete();
    kind = $urandom_range(0, 9);
    nseq = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 5);
    for (int s = 0; s < nseq; s++) begin
      if (kind <= 5 || kind == 9) begin
        k = $urandom_range(0, 5);
        if (k == 0) begin
          text_q.push_back(8'($urandom_range(1, 127)));
        end else begin
          text_q.push_back(lead_byte(k));
          for (int c = 0; c < k; c++) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
      end else if (kind <= 7) begin
        k = $urandom_range(0, SetBytes - 1);
        case ($urandom_range(0, 2))
          0:       text_q.push_back(board.iso_set[k*8 +: 8]);
          1:       text_q.push_back(board.cp_set[k*8 +: 8]);
          default: text_q.push_back(8'($urandom_range(1, 255)));
        endcase
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (kind <= 5 && text_q.size() > 1 && $urandom_range(0, 3) == 0) void'(text_q.pop_back());
    if (kind == 9) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) text_q.insert($urandom_range(0, text_q.size()), 8'h00);
  endfunction

  initial begin
    int sent;
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    read_check(REG_ISO_LETTERS);
    read_check(REG_CP_LETTERS);
    foreach (DirectedText[i]) offer(DirectedText[i][7:0], DirectedText[i][8]);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) load_sets(p);
      sent = 0;
      while (sent < PhaseItems) begin
        build_text();
        foreach (text_q[i]) offer(text_q[i], i == text_q.size() - 1);
        sent += text_q.size();
      end
      wait_idle();
    end

    $display("Covered %0d text bytes in %0d buffers: UTF-8 %0d, CP1250 %0d, ISO-8859-2 %0d.",
             board.bytes_seen, board.verdicts_seen, board.cs_count[CS_UTF8],
             board.cs_count[CS_CP1250], board.cs_count[CS_ISO8859]);
    $display("%0d letter-set writes over %0d settings; input back-pressured %0d cycles.",
             reg_writes, NumPhases, stall_cycles);
    if (board.errors == 0 && board.pending_verdicts.size() == 0) begin
      $display("text_charset_detector_top test passed");
    end else begin
      $display("text_charset_detector_top test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("text_charset_detector_top test failed");
    $finish;
  end

endmodule
